[sv/hpg_pkg.sv]
`timescale 1ns / 1ps
// Package: shared types and constants of the heater PWM gate.
package hpg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MIN_DUTY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TENTH  = 2'd2;

	localparam logic [1:0] FUNC_SET_DRIVE     = 2'd0;
	localparam logic [1:0] FUNC_PERIOD        = 2'd1;
	localparam logic [1:0] FUNC_PULSE_FINISHED = 2'd2;

	localparam logic [2:0] MODE_SOLDERING   = 3'd1;
	localparam logic [2:0] MODE_SLEEPING    = 3'd2;
	localparam logic [2:0] MODE_HIBERNATING = 3'd3;
	localparam logic [2:0] MODE_RUNAWAY     = 3'd4;

	localparam logic [4:0]  SAFETY_RELOAD    = 5'd20;
	localparam int          POWER_TICKS      = 255;
	localparam int          GUARD_TICKS      = 14;
	localparam int          FAST_PRESCALE    = 2690;
	localparam logic [15:0] NO_SAMPLE        = 16'hFFFF;
	localparam int          TENTHS_SOLDERING = 5;

	localparam logic [8:0]  PERIOD_TOP_FAST  = 9'(POWER_TICKS + 2 * GUARD_TICKS);
	localparam logic [8:0]  PERIOD_TOP_SLOW  = 9'(POWER_TICKS + 2 * (GUARD_TICKS / 2));
	localparam logic [8:0]  ADC_CMP_FAST     = 9'(POWER_TICKS + GUARD_TICKS);
	localparam logic [8:0]  ADC_CMP_SLOW     = 9'(POWER_TICKS + GUARD_TICKS / 2);
	localparam logic [12:0] PRESCALE_FAST    = 13'(FAST_PRESCALE);
	localparam logic [12:0] PRESCALE_SLOW    = 13'(FAST_PRESCALE * 2);

	typedef struct packed {
		logic [7:0]  sample_min_duty;
		logic [15:0] ticks_per_second;
		logic [15:0] ticks_per_tenth;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  drive_level;
		logic        fast_request;
		logic [31:0] now_tick;
		logic [2:0]  op_mode;
		logic        tip_disconnected;
	} in_item_t;

	typedef struct packed {
		logic [15:0] sample_compare;
		logic [7:0]  drive_compare;
		logic        drive_enable;
		logic [8:0]  period_top;
		logic [8:0]  adc_compare;
		logic [12:0] prescale;
		logic        fast_active;
		logic        sampling_now;
	} out_item_t;

endpackage

[sv/hpg_in_if.sv]
`timescale 1ns / 1ps
// Interface: command channel of the heater PWM gate.
interface hpg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  drive_level;
	logic        fast_request;
	logic [31:0] now_tick;
	logic [2:0]  op_mode;
	logic        tip_disconnected;

	modport source (output valid, func, drive_level, fast_request, now_tick, op_mode,
		tip_disconnected, input ready);
	modport sink (input valid, func, drive_level, fast_request, now_tick, op_mode,
		tip_disconnected, output ready);
endinterface

[sv/hpg_out_if.sv]
`timescale 1ns / 1ps
// Interface: result channel of the heater PWM gate.
interface hpg_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_compare;
	logic [7:0]  drive_compare;
	logic        drive_enable;
	logic [8:0]  period_top;
	logic [8:0]  adc_compare;
	logic [12:0] prescale;
	logic        fast_active;
	logic        sampling_now;

	modport source (output valid, sample_compare, drive_compare, drive_enable, period_top,
		adc_compare, prescale, fast_active, sampling_now, input ready);
	modport sink (input valid, sample_compare, drive_compare, drive_enable, period_top,
		adc_compare, prescale, fast_active, sampling_now, output ready);
endinterface

[sv/hpg_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration registers of the heater PWM gate.
module hpg_cfg_regs import hpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_min_duty  <= 8'd0;
			cfg_q.ticks_per_second <= 16'd1000;
			cfg_q.ticks_per_tenth  <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLE_MIN_DUTY:  cfg_q.sample_min_duty  <= cfg_data[7:0];
				CFG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data;
				CFG_TICKS_PER_TENTH:  cfg_q.ticks_per_tenth  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/hpg_core.sv]
`timescale 1ns / 1ps
// Gate state and the next-result logic for one command word.
module hpg_core import hpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      update,
	input  in_item_t  item,
	output out_item_t result
);

	logic [4:0]  safety_q;
	logic [7:0]  duty_q;
	logic        fast_wanted_q;
	logic        fast_in_use_q;
	logic [31:0] last_tick_q;
	logic        pending_q;
	logic [15:0] sample_cmp_q;
	logic [7:0]  drive_cmp_q;
	logic        drive_on_q;

	logic [4:0]  safety_d;
	logic [7:0]  duty_d;
	logic        fast_wanted_d;
	logic        fast_in_use_d;
	logic [31:0] last_tick_d;
	logic        pending_d;
	logic [15:0] sample_cmp_d;
	logic [7:0]  drive_cmp_d;
	logic        drive_on_d;

	logic [4:0]  safety_dec;
	logic [18:0] interval;
	logic [31:0] elapsed;
	logic        allowed;
	logic        due;
	logic        take_sample;
	logic [7:0]  duty_period;

	always_comb begin
		safety_dec = (safety_q != 5'd0) ? safety_q - 5'd1 : 5'd0;

		if (item.tip_disconnected) begin
			interval = {3'd0, cfg.ticks_per_second};
		end else if (item.op_mode == MODE_SOLDERING) begin
			if (duty_q >= cfg.sample_min_duty) begin
				// Times five as shift and add.
				interval = {1'b0, cfg.ticks_per_tenth, 2'd0} + {3'd0, cfg.ticks_per_tenth};
			end else begin
				interval = {3'd0, cfg.ticks_per_second};
			end
		end else begin
			interval = {2'd0, cfg.ticks_per_second, 1'b0};
		end

		allowed = !(item.op_mode == MODE_SLEEPING || item.op_mode == MODE_HIBERNATING ||
			item.op_mode == MODE_RUNAWAY);
		elapsed = item.now_tick - last_tick_q;
		due = (last_tick_q == 32'd0) || (elapsed > {13'd0, interval});
		take_sample = allowed && due;
		duty_period = (take_sample && duty_q < cfg.sample_min_duty) ? cfg.sample_min_duty
			: duty_q;
	end

	always_comb begin
		safety_d      = safety_q;
		duty_d        = duty_q;
		fast_wanted_d = fast_wanted_q;
		fast_in_use_d = fast_in_use_q;
		last_tick_d   = last_tick_q;
		pending_d     = pending_q;
		sample_cmp_d  = sample_cmp_q;
		drive_cmp_d   = drive_cmp_q;
		drive_on_d    = drive_on_q;
		case (item.func)
			FUNC_SET_DRIVE: begin
				safety_d      = SAFETY_RELOAD;
				fast_wanted_d = item.fast_request;
				duty_d        = item.drive_level;
			end
			FUNC_PERIOD: begin
				safety_d = safety_dec;
				duty_d   = duty_period;
				if (take_sample) begin
					sample_cmp_d = {9'd0, duty_period[7:1]};
					pending_d    = 1'b1;
				end else begin
					sample_cmp_d = NO_SAMPLE;
				end
				// The compare keeps its last loaded value when drive stops.
				if (duty_period != 8'd0 && safety_dec != 5'd0) begin
					drive_cmp_d = duty_period;
					drive_on_d  = 1'b1;
				end else begin
					drive_on_d = 1'b0;
				end
				fast_in_use_d = fast_wanted_q;
			end
			FUNC_PULSE_FINISHED: begin
				drive_on_d = 1'b0;
				if (pending_q) begin
					last_tick_d = item.now_tick;
					pending_d   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safety_q      <= 5'd0;
			duty_q        <= 8'd0;
			fast_wanted_q <= 1'b0;
			fast_in_use_q <= 1'b1;
			last_tick_q   <= 32'd0;
			pending_q     <= 1'b0;
			sample_cmp_q  <= 16'd0;
			drive_cmp_q   <= 8'd0;
			drive_on_q    <= 1'b0;
		end else if (update) begin
			safety_q      <= safety_d;
			duty_q        <= duty_d;
			fast_wanted_q <= fast_wanted_d;
			fast_in_use_q <= fast_in_use_d;
			last_tick_q   <= last_tick_d;
			pending_q     <= pending_d;
			sample_cmp_q  <= sample_cmp_d;
			drive_cmp_q   <= drive_cmp_d;
			drive_on_q    <= drive_on_d;
		end
	end

	always_comb begin
		result.sample_compare = sample_cmp_d;
		result.drive_compare  = drive_cmp_d;
		result.drive_enable   = drive_on_d;
		result.fast_active    = fast_in_use_d;
		result.sampling_now   = pending_d;
		result.period_top     = fast_in_use_d ? PERIOD_TOP_FAST : PERIOD_TOP_SLOW;
		result.adc_compare    = fast_in_use_d ? ADC_CMP_FAST : ADC_CMP_SLOW;
		result.prescale       = fast_in_use_d ? PRESCALE_FAST : PRESCALE_SLOW;
	end

endmodule

[sv/heater_pwm_gate_with_sample_scheduler.sv]
`timescale 1ns / 1ps
// Heater PWM gate with current-sample scheduler, top level.
//
// Commands arrive on cmd: set_drive, period_elapsed or pulse_finished, with the
// current tick, operating mode and tip-disconnect flag. Each command word gives
// exactly one result word on res, carrying the heater compare values, enables
// and the period timing in effect after that command.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the sample
// minimum duty and the tick counts; write it only while no command is in flight.
// A command is captured in an input register and its result is loaded into the
// output register once it is free or being read, which raises res.valid. One
// command is accepted every cycle while results are taken; the gate state update is
// a single compare-and-select step between the two registers.
// Reset clears the gate state, selects fast period timing and loads the
// register defaults. When the receiver stalls, the result holds in the output
// register and cmd.ready stays low while the input register holds a word.
module heater_pwm_gate_with_sample_scheduler import hpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hpg_in_if.sink                cmd,
	hpg_out_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t res_s2;
	logic      valid_s2;
	logic      advance;

	hpg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hpg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.update (valid_s1 && advance),
		.item   (item_s1),
		.result (result)
	);

	assign advance   = !valid_s2 || res.ready;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.func             <= cmd.func;
			item_s1.drive_level      <= cmd.drive_level;
			item_s1.fast_request     <= cmd.fast_request;
			item_s1.now_tick         <= cmd.now_tick;
			item_s1.op_mode          <= cmd.op_mode;
			item_s1.tip_disconnected <= cmd.tip_disconnected;
		end
		if (advance && valid_s1) begin
			res_s2 <= result;
		end
	end

	assign res.valid          = valid_s2;
	assign res.sample_compare = res_s2.sample_compare;
	assign res.drive_compare  = res_s2.drive_compare;
	assign res.drive_enable   = res_s2.drive_enable;
	assign res.period_top     = res_s2.period_top;
	assign res.adc_compare    = res_s2.adc_compare;
	assign res.prescale       = res_s2.prescale;
	assign res.fast_active    = res_s2.fast_active;
	assign res.sampling_now   = res_s2.sampling_now;

endmodule

[sv/hpg_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the heater PWM gate and its bind to the top level.
module hpg_checker import hpg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  drive_compare,
	input logic        drive_enable,
	input logic [8:0]  period_top,
	input logic [8:0]  adc_compare,
	input logic [12:0] prescale,
	input logic        fast_active
);

	// A stalled result word stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// Fast timing shows the full set of fast values.
	a_fast_timing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fast_active |-> period_top == PERIOD_TOP_FAST &&
			adc_compare == ADC_CMP_FAST && prescale == PRESCALE_FAST)
		else $error("fast timing values inconsistent");

	// Slow timing shows the full set of slow values.
	a_slow_timing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fast_active |-> period_top == PERIOD_TOP_SLOW &&
			adc_compare == ADC_CMP_SLOW && prescale == PRESCALE_SLOW)
		else $error("slow timing values inconsistent");

	// The heater only runs with a nonzero compare loaded.
	a_drive_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_enable |-> drive_compare != 8'd0)
		else $error("drive enabled with zero compare");

endmodule

bind heater_pwm_gate_with_sample_scheduler hpg_checker u_hpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (res.valid),
	.out_ready     (res.ready),
	.drive_compare (res.drive_compare),
	.drive_enable  (res.drive_enable),
	.period_top    (res.period_top),
	.adc_compare   (res.adc_compare),
	.prescale      (res.prescale),
	.fast_active   (res.fast_active)
);

[test/tb_heater_pwm_gate_with_sample_scheduler.sv]
`timescale 1ns / 1ps
// Testbench: randomized command streams against a cycle-free shadow of the heater PWM gate.
module tb_heater_pwm_gate_with_sample_scheduler import hpg_pkg::*;;

	// Shadow copy of the gate state; it predicts one result word per accepted command.
	class heater_gate_shadow;
		logic [7:0]  min_duty;
		logic [15:0] per_second;
		logic [15:0] per_tenth;
		logic [4:0]  safety;
		logic [7:0]  duty;
		logic        fast_wanted;
		logic        fast_in_use;
		logic [31:0] last_tick;
		logic        pending;
		logic [15:0] sample_cmp;
		logic [7:0]  drive_cmp;
		logic        drive_on;
		out_item_t   expected_words[$];
		int          errors;
		int          reports;

		function new();
			min_duty = 8'd0;
			per_second = 16'd1000;
			per_tenth = 16'd100;
			safety = 5'd0;
			duty = 8'd0;
			fast_wanted = 1'b0;
			fast_in_use = 1'b1;
			last_tick = 32'd0;
			pending = 1'b0;
			sample_cmp = 16'd0;
			drive_cmp = 8'd0;
			drive_on = 1'b0;
			errors = 0;
			reports = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_SAMPLE_MIN_DUTY: min_duty = data[7:0];
				CFG_TICKS_PER_SECOND: per_second = data;
				CFG_TICKS_PER_TENTH: per_tenth = data;
				default: ;
			endcase
		endfunction

		function logic [31:0] sample_interval(logic [2:0] mode, logic tip_off);
			if (tip_off)
				return {16'd0, per_second};
			if (mode == MODE_SOLDERING) begin
				if (duty >= min_duty)
					return {16'd0, per_tenth} * 32'(TENTHS_SOLDERING);
				return {16'd0, per_second};
			end
			return {16'd0, per_second} * 32'd2;
		endfunction

		function void note_command(in_item_t cmd_word);
			logic [31:0] interval;
			logic        allowed;
			out_item_t   want;
			case (cmd_word.func)
				FUNC_SET_DRIVE: begin
					safety = SAFETY_RELOAD;
					fast_wanted = cmd_word.fast_request;
					duty = cmd_word.drive_level;
				end
				FUNC_PERIOD: begin
					if (safety != 5'd0)
						safety = safety - 5'd1;
					interval = sample_interval(cmd_word.op_mode, cmd_word.tip_disconnected);
					allowed = cmd_word.op_mode != MODE_SLEEPING &&
						cmd_word.op_mode != MODE_HIBERNATING && cmd_word.op_mode != MODE_RUNAWAY;
					if (allowed && (last_tick == 32'd0 ||
						(cmd_word.now_tick - last_tick) > interval)) begin
						if (duty < min_duty)
							duty = min_duty;
						sample_cmp = {9'd0, duty[7:1]};
						pending = 1'b1;
					end else begin
						sample_cmp = NO_SAMPLE;
					end
					if (duty != 8'd0 && safety != 5'd0) begin
						drive_cmp = duty;
						drive_on = 1'b1;
					end else begin
						drive_on = 1'b0;
					end
					fast_in_use = fast_wanted;
				end
				FUNC_PULSE_FINISHED: begin
					drive_on = 1'b0;
					if (pending) begin
						last_tick = cmd_word.now_tick;
						pending = 1'b0;
					end
				end
				default: ;
			endcase
			want.sample_compare = sample_cmp;
			want.drive_compare = drive_cmp;
			want.drive_enable = drive_on;
			want.period_top = fast_in_use ? PERIOD_TOP_FAST : PERIOD_TOP_SLOW;
			want.adc_compare = fast_in_use ? ADC_CMP_FAST : ADC_CMP_SLOW;
			want.prescale = fast_in_use ? PRESCALE_FAST : PRESCALE_SLOW;
			want.fast_active = fast_in_use;
			want.sampling_now = pending;
			expected_words.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (reports < 60)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				reports++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (reports < 60)
					$display("%0t: result word expected none, got %h", $time, got);
				reports++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("sample_compare", 32'(want.sample_compare), 32'(got.sample_compare));
			compare_field("drive_compare", 32'(want.drive_compare), 32'(got.drive_compare));
			compare_field("drive_enable", 32'(want.drive_enable), 32'(got.drive_enable));
			compare_field("period_top", 32'(want.period_top), 32'(got.period_top));
			compare_field("adc_compare", 32'(want.adc_compare), 32'(got.adc_compare));
			compare_field("prescale", 32'(want.prescale), 32'(got.prescale));
			compare_field("fast_active", 32'(want.fast_active), 32'(got.fast_active));
			compare_field("sampling_now", 32'(want.sampling_now), 32'(got.sampling_now));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hpg_in_if  cmd_if();
	hpg_out_if res_if();

	heater_gate_shadow gate = new();

	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	logic [31:0] tick;

	heater_pwm_gate_with_sample_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are observed before the edge updates anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				gate.note_command({cmd_if.func, cmd_if.drive_level, cmd_if.fast_request,
					cmd_if.now_tick, cmd_if.op_mode, cmd_if.tip_disconnected});
			if (res_if.valid && res_if.ready)
				gate.check_result({res_if.sample_compare, res_if.drive_compare,
					res_if.drive_enable, res_if.period_top, res_if.adc_compare,
					res_if.prescale, res_if.fast_active, res_if.sampling_now});
		end
	end

	// Result receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_if.ready = 1'b0;
				hold_cycles--;
			end else begin
				res_if.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic in_item_t make_cmd(logic [1:0] func, logic [7:0] level, logic fast,
		logic [31:0] now, logic [2:0] mode, logic tip_off);
		in_item_t cmd_word;
		cmd_word.func = func;
		cmd_word.drive_level = level;
		cmd_word.fast_request = fast;
		cmd_word.now_tick = now;
		cmd_word.op_mode = mode;
		cmd_word.tip_disconnected = tip_off;
		return cmd_word;
	endfunction

	task automatic send_cmd(input in_item_t cmd_word);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			cmd_if.valid = 1'b0;
		end
		@(negedge clk);
		cmd_if.valid = 1'b1;
		cmd_if.func = cmd_word.func;
		cmd_if.drive_level = cmd_word.drive_level;
		cmd_if.fast_request = cmd_word.fast_request;
		cmd_if.now_tick = cmd_word.now_tick;
		cmd_if.op_mode = cmd_word.op_mode;
		cmd_if.tip_disconnected = cmd_word.tip_disconnected;
		do
			@(posedge clk);
		while (cmd_if.ready !== 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		gate.write_register(index, data);
	endtask

	task automatic configure(input logic [7:0] min_duty, input logic [15:0] per_second,
		input logic [15:0] per_tenth);
		write_reg(CFG_SAMPLE_MIN_DUTY, {8'd0, min_duty});
		write_reg(CFG_TICKS_PER_SECOND, per_second);
		write_reg(CFG_TICKS_PER_TENTH, per_tenth);
	endtask

	// Registers change only once the last word is out and the pipeline is empty.
	task automatic wait_drained();
		@(negedge clk);
		cmd_if.valid = 1'b0;
		while (gate.expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed drive cycles: set_drive, then a run of periods each
	// usually closed by pulse_finished, with ticks advancing around the intervals.
	task automatic run_random(input int count);
		int          issued;
		int          burst;
		logic [7:0]  level;
		logic [2:0]  mode;
		logic [31:0] step;
		in_item_t    noise;
		issued = 0;
		while (issued < count) begin
			if ($urandom_range(99) < 12) begin
				noise = make_cmd(2'($urandom), 8'($urandom), 1'($urandom), $urandom,
					3'($urandom), 1'($urandom));
				send_cmd(noise);
				issued++;
			end else begin
				case ($urandom_range(9))
					0: level = 8'hFF;
					1: level = 8'h00;
					default: level = 8'($urandom);
				endcase
				send_cmd(make_cmd(FUNC_SET_DRIVE, level, 1'($urandom), tick, 3'($urandom),
					1'($urandom)));
				issued++;
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					case ($urandom_range(9))
						0: step = $urandom;
						1, 2: step = $urandom_range(0, 3);
						3, 4, 5: step = $urandom_range(0, 2 * gate.per_second + 2);
						default: step = $urandom_range(0, 5 * gate.per_tenth + 2);
					endcase
					tick = tick + step;
					mode = ($urandom_range(99) < 50) ? MODE_SOLDERING : 3'($urandom_range(7));
					send_cmd(make_cmd(FUNC_PERIOD, 8'($urandom), 1'($urandom), tick, mode,
						$urandom_range(99) < 15));
					issued++;
					if ($urandom_range(99) < 75) begin
						tick = tick + $urandom_range(0, 3);
						send_cmd(make_cmd(FUNC_PULSE_FINISHED, 8'($urandom), 1'($urandom), tick,
							3'($urandom), 1'($urandom)));
						issued++;
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_if.valid = 1'b0;
		cmd_if.func = FUNC_SET_DRIVE;
		cmd_if.drive_level = 8'd0;
		cmd_if.fast_request = 1'b0;
		cmd_if.now_tick = 32'd0;
		cmd_if.op_mode = 3'd0;
		cmd_if.tip_disconnected = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		tick = 32'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		configure(8'd0, 16'd1000, 16'd100);

		// Directed part under the default tick counts.
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd0, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_SET_DRIVE, 8'hFF, 1'b1, 32'd0, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd10, MODE_SOLDERING, 1'b0));
		send_cmd(make_cmd(FUNC_PULSE_FINISHED, 8'd0, 1'b0, 32'hFFFF_FFFF, 3'd0, 1'b0));
		// The tick wraps between the stamp and this period.
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd500, MODE_SOLDERING, 1'b0));
		send_cmd(make_cmd(FUNC_PULSE_FINISHED, 8'd0, 1'b0, 32'd500, 3'd0, 1'b0));
		// Exactly at the interval is not yet due; one tick later is.
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd1000, MODE_SOLDERING, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd1001, MODE_SOLDERING, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd5000, MODE_SOLDERING, 1'b0));
		send_cmd(make_cmd(FUNC_PULSE_FINISHED, 8'd0, 1'b0, 32'd5000, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd7000, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd7001, 3'd7, 1'b0));
		send_cmd(make_cmd(FUNC_PULSE_FINISHED, 8'd0, 1'b0, 32'd7001, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd9000, MODE_SLEEPING, 1'b1));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd9000, MODE_HIBERNATING, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd9000, MODE_RUNAWAY, 1'b1));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd8002, 3'd0, 1'b1));
		send_cmd(make_cmd(FUNC_SET_DRIVE, 8'd0, 1'b0, 32'd0, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd8003, 3'd5, 1'b0));
		send_cmd(make_cmd(2'd3, 8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd7, 1'b1));
		send_cmd(make_cmd(FUNC_PULSE_FINISHED, 8'd0, 1'b0, 32'd0, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_SET_DRIVE, 8'd1, 1'b1, 32'd0, 3'd0, 1'b0));
		send_cmd(make_cmd(FUNC_PERIOD, 8'd0, 1'b0, 32'd1, MODE_SOLDERING, 1'b0));

		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					configure(8'd0, 16'd1000, 16'd100);
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					configure(8'd255, 16'd1, 16'd65535);
					send_idle_pct = 69;
					recv_stall_pct = 0;
				end
				2: begin
					configure(8'd1, 16'd65535, 16'd1);
					send_idle_pct = 0;
					recv_stall_pct = 69;
				end
				default: begin
					configure(8'($urandom), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)));
					send_idle_pct = 9;
					recv_stall_pct = 9;
				end
			endcase
			tick = ($urandom_range(3) == 0) ? 32'hFFFF_0000 + $urandom_range(65535) : $urandom;
			if (phase == 0) begin
				// Long receiver hold-off with the sender offering every cycle.
				@(posedge clk);
				hold_cycles = 60;
			end
			run_random(120);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (gate.errors == 0 && gate.expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
